// File: hdl/smpq_pkg.sv
package smpq_pkg;

  // Configuration register
  localparam int unsigned CAP_BITS = 7;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

  // Request opcode
  typedef enum logic [0:0] {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  // Result status
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PUT,
    S_DEQ,
    S_FIN
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic in_ready;    // idle, can take a request
    logic scan_shift;  // move scanned entry up one slot
    logic scan_stop;   // drop new entry above scanned one
    logic put;         // write new entry at write pointer
    logic deq_cap;     // capture head entry
    logic fin_load;    // commit and load result register
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_fire;     // request taken this cycle
    logic in_deq;      // request is a dequeue
    logic full;
    logic empty;
    logic greater;     // scanned key above new key
    logic j_zero;      // scan reached the head
    logic out_free;    // result register free this cycle
  } dp_stat_t;

endpackage

// File: hdl/smpq_in_if.sv
interface smpq_in_if
  import smpq_pkg::*;
#(
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 16
) ();
  logic                valid;
  logic                ready;
  cmd_t                cmd;
  logic [KEY_BITS-1:0] key;
  logic [TAG_BITS-1:0] tag;

  modport source (output valid, cmd, key, tag, input ready);
  modport sink   (input valid, cmd, key, tag, output ready);
endinterface

// File: hdl/smpq_out_if.sv
interface smpq_out_if
  import smpq_pkg::*;
#(
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 16,
  parameter int CNT_W    = 7
) ();
  logic                valid;
  logic                ready;
  status_t             status;
  logic [KEY_BITS-1:0] out_key;
  logic [TAG_BITS-1:0] out_tag;
  logic [CNT_W-1:0]    occupancy;

  modport source (output valid, status, out_key, out_tag, occupancy, input ready);
  modport sink   (input valid, status, out_key, out_tag, occupancy, output ready);
endinterface

// File: hdl/smpq_ram.sv
module smpq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/smpq_ctrl.sv
module smpq_ctrl
  import smpq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (stat.in_fire) begin
          if (stat.in_deq) begin
            state_nxt = stat.empty ? S_FIN : S_DEQ;
          end else if (stat.full) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = stat.empty ? S_PUT : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!stat.greater) begin
          state_nxt = S_FIN;
        end else if (stat.j_zero) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT:   state_nxt = S_FIN;
      S_DEQ:   state_nxt = S_FIN;
      S_FIN:   state_nxt = stat.out_free ? S_IDLE : S_FIN;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: cmd.in_ready = 1'b1;
      S_SCAN: begin
        cmd.scan_shift = stat.greater;
        cmd.scan_stop  = !stat.greater;
      end
      S_PUT:   cmd.put = 1'b1;
      S_DEQ:   cmd.deq_cap = 1'b1;
      S_FIN:   cmd.fin_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: hdl/smpq_dp.sv
module smpq_dp
  import smpq_pkg::*;
#(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CAP_BITS-1:0] cfg_data,
  smpq_in_if.sink             in_chan,
  smpq_out_if.source          out_chan,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;
  localparam int EW    = KEY_BITS + TAG_BITS;

  // Ring pointer step with wrap
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
  endfunction

  logic [CAP_BITS-1:0] cap_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [AW-1:0]       tail_r, tail_nxt;
  logic [AW-1:0]       p_r;
  logic [AW-1:0]       wp_r;
  logic [CNT_W-1:0]    j_r;
  logic                op_deq_r;
  status_t             status_r;
  logic [KEY_BITS-1:0] key_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [KEY_BITS-1:0] hold_key_r;
  logic [TAG_BITS-1:0] hold_tag_r;
  logic                out_valid_r;
  status_t             out_status_r;
  logic [KEY_BITS-1:0] out_key_r;
  logic [TAG_BITS-1:0] out_tag_r;
  logic [CNT_W-1:0]    out_occ_r;

  logic                accept;
  logic                full;
  logic                empty;
  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  logic [EW-1:0]       ram_wdata;
  logic [EW-1:0]       ram_rdata;
  logic [KEY_BITS-1:0] rd_key;
  logic [TAG_BITS-1:0] rd_tag;

  assign accept = in_chan.valid && cmd.in_ready;
  assign in_chan.ready = cmd.in_ready;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH)) ||
                 (CMP_W'(count_r) >= CMP_W'(cap_r));

  assign rd_key = ram_rdata[TAG_BITS +: KEY_BITS];
  assign rd_tag = ram_rdata[TAG_BITS-1:0];

  // Status to controller
  always_comb begin
    stat.in_fire  = accept;
    stat.in_deq   = (in_chan.cmd == CMD_DEQ);
    stat.full     = full;
    stat.empty    = empty;
    stat.greater  = rd_key > key_r;
    stat.j_zero   = (j_r == '0);
    stat.out_free = !out_valid_r || out_chan.ready;
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_data;
    end
  end

  // Entry store: read head for dequeue or tail-1 to start a scan, then the entry below the scanned one
  always_comb begin
    if (cmd.in_ready) begin
      ram_raddr = (in_chan.cmd == CMD_DEQ) ? head_r : ptr_dec(tail_r);
    end else begin
      ram_raddr = ptr_dec(p_r);
    end
  end

  assign ram_we    = cmd.scan_shift || cmd.scan_stop || cmd.put;
  assign ram_wdata = cmd.scan_shift ? ram_rdata : {key_r, tag_r};

  smpq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Request capture and scan pointers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_deq_r <= (in_chan.cmd == CMD_DEQ);
      key_r    <= in_chan.key;
      tag_r    <= in_chan.tag;
      wp_r     <= tail_r;
      p_r      <= ptr_dec(tail_r);
      j_r      <= count_r - 1'b1;
      if (in_chan.cmd == CMD_DEQ) begin
        status_r <= empty ? ST_EMPTY : ST_DONE;
      end else begin
        status_r <= full ? ST_FULL : ST_DONE;
      end
    end else if (cmd.scan_shift) begin
      wp_r <= p_r;
      p_r  <= ptr_dec(p_r);
      j_r  <= j_r - 1'b1;
    end
    if (cmd.deq_cap) begin
      hold_key_r <= rd_key;
      hold_tag_r <= rd_tag;
    end
  end

  // Commit of count and ring pointers
  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    if (status_r == ST_DONE) begin
      if (op_deq_r) begin
        count_nxt = count_r - 1'b1;
        head_nxt  = ptr_inc(head_r);
      end else begin
        count_nxt = count_r + 1'b1;
        tail_nxt  = ptr_inc(tail_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
    end else if (cmd.fin_load) begin
      count_r <= count_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_load) begin
      out_status_r <= status_r;
      out_occ_r    <= count_nxt;
      if (op_deq_r && status_r == ST_DONE) begin
        out_key_r <= hold_key_r;
        out_tag_r <= hold_tag_r;
      end else begin
        out_key_r <= '0;
        out_tag_r <= '0;
      end
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.out_key   = out_key_r;
  assign out_chan.out_tag   = out_tag_r;
  assign out_chan.occupancy = out_occ_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == tail_r) |-> (count_r == '0 || count_r == CNT_W'(DEPTH)))
    else $error("ring pointers disagree with entry count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_load |-> (!out_valid_r || out_chan.ready))
    else $error("result loaded over an untaken result");

  a_refused_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin_load && status_r != ST_DONE) |=> (count_r == $past(count_r)))
    else $error("refused request changed the entry count");

endmodule

// File: hdl/sorted_min_priority_queue_core.sv
// Minimum priority queue holding up to DEPTH key/tag entries in key order.
// Requests arrive on in_chan (valid/ready): cmd selects enqueue or dequeue,
// key and tag are used on enqueue. Each request produces one result on
// out_chan: status, the removed key and tag on a good dequeue (zero
// otherwise), and the occupancy after the request. Equal keys leave in
// arrival order. cfg_we/cfg_data write the capacity limit (reset 64); the
// effective limit is the smaller of capacity and DEPTH.
// Entries sit in one single-port-write RAM used as a ring. A request is
// taken when the controller is idle, which is the cycle after the previous
// result is loaded. A dequeue reads the head (DEQ) and then loads the result
// (FIN); a refused request goes straight to FIN; an enqueue walks from the
// tail toward the head over entries with a larger key (SCAN), moving one entry
// up per cycle, writes the new entry (in SCAN or PUT) and then loads the
// result (FIN). Only one request is in flight at a time.
// A held result does not stop the next request from being taken; only its
// final commit waits until out_chan.ready frees the result register.
// Reset (rst_n, synchronous) empties the queue; RAM contents are not cleared.
module sorted_min_priority_queue_core
  import smpq_pkg::*;
#(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CAP_BITS-1:0] cfg_data,
  smpq_in_if.sink             in_chan,
  smpq_out_if.source          out_chan
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  smpq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (dp_stat),
    .cmd   (dp_cmd)
  );

  smpq_dp #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cmd      (dp_cmd),
    .stat     (dp_stat)
  );

endmodule

// File: tb/smpq_order_checker.sv
`timescale 1ns / 100ps

module smpq_order_checker
  import smpq_pkg::*;
#(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CAP_BITS-1:0] cfg_data,
  smpq_in_if                  in_mon,
  smpq_out_if                 out_mon,
  output int                  fail_count,
  output int                  owed_count
);

  typedef struct {
    status_t             status;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
    logic [CAP_BITS-1:0] occupancy;
  } queue_result_t;

  // Shadow of the queue: ascending keys, equal keys in arrival order
  logic [KEY_BITS-1:0] slot_key [DEPTH];
  logic [TAG_BITS-1:0] slot_tag [DEPTH];
  int unsigned         entries;
  logic [CAP_BITS-1:0] capacity;

  // Results the block still owes, oldest first
  queue_result_t owed_results [$];

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Apply one request to the shadow queue and return its result
  function automatic queue_result_t apply_queue_op(input cmd_t op,
                                                   input logic [KEY_BITS-1:0] key,
                                                   input logic [TAG_BITS-1:0] tag);
    queue_result_t r;
    int unsigned   limit;
    int unsigned   pos;
    int unsigned   i;
    r.status = ST_DONE;
    r.key    = '0;
    r.tag    = '0;
    limit    = (capacity < DEPTH) ? capacity : DEPTH;
    if (op == CMD_ENQ) begin
      if (entries >= limit) begin
        r.status = ST_FULL;
      end else begin
        // land behind every entry with a key not above the new one
        pos = 0;
        while (pos < entries && slot_key[pos] <= key) pos++;
        for (i = entries; i > pos; i--) begin
          slot_key[i] = slot_key[i-1];
          slot_tag[i] = slot_tag[i-1];
        end
        slot_key[pos] = key;
        slot_tag[pos] = tag;
        entries++;
      end
    end else begin
      if (entries == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.key = slot_key[0];
        r.tag = slot_tag[0];
        for (i = 1; i < entries; i++) begin
          slot_key[i-1] = slot_key[i];
          slot_tag[i-1] = slot_tag[i];
        end
        entries--;
      end
    end
    r.occupancy = entries[CAP_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      entries  = 0;
      capacity = CAP_RESET;
      owed_results.delete();
    end else begin
      if (cfg_we) capacity = cfg_data;
      // results always trail their request, so match before adding new ones
      if (out_mon.valid && out_mon.ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = owed_results.pop_front();
          if (out_mon.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_mon.status, want.status));
          if (out_mon.out_key !== want.key)
            report_mismatch($sformatf("out_key got %h want %h",
                                      out_mon.out_key, want.key));
          if (out_mon.out_tag !== want.tag)
            report_mismatch($sformatf("out_tag got %h want %h",
                                      out_mon.out_tag, want.tag));
          if (out_mon.occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy got %0d want %0d",
                                      out_mon.occupancy, want.occupancy));
        end
      end
      if (in_mon.valid && in_mon.ready)
        owed_results.push_back(apply_queue_op(in_mon.cmd, in_mon.key, in_mon.tag));
    end
    owed_count = owed_results.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import smpq_pkg::*;

  localparam int KEY_BITS    = 32;
  localparam int TAG_BITS    = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 100;
  localparam int PHASES      = 9;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CAP_BITS-1:0] cfg_data;
  int                  fail_count;
  int                  owed_count;
  int                  cycle_count;
  int                  gap_pct;
  int                  stall_pct;

  // Per-phase capacity, share of enqueues in percent, request count
  logic [CAP_BITS-1:0] phase_cap [PHASES];
  int                  phase_enq [PHASES];
  int                  phase_len [PHASES];

  smpq_in_if  in_chan ();
  smpq_out_if out_chan ();

  sorted_min_priority_queue_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  smpq_order_checker queue_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .owed_count (owed_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Result-side back-pressure in random bursts
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(1, 100) <= stall_pct) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
    end
  end

  // Run-away guard
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Present one request and hold it until taken; valid stays high on return
  task automatic send_request(input cmd_t op, input logic [KEY_BITS-1:0] key,
                              input logic [TAG_BITS-1:0] tag);
    if ($urandom_range(1, 100) <= gap_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.cmd   <= op;
    in_chan.key   <= key;
    in_chan.tag   <= tag;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (owed_count != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] value);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Keys lean toward ties and extremes so ordering is stressed
  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1:    pick_key = KEY_BITS'($urandom_range(0, 7));
      2:       pick_key = $urandom_range(0, 1) ? '1 : '0;
      3:       pick_key = {1'b1, (KEY_BITS-1)'($urandom_range(0, 3))};
      default: pick_key = KEY_BITS'($urandom);
    endcase
  endfunction

  initial begin
    int p;
    int n;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_data      <= '0;
    in_chan.valid <= 1'b0;
    in_chan.cmd   <= CMD_ENQ;
    in_chan.key   <= '0;
    in_chan.tag   <= '0;
    gap_pct   = 0;
    stall_pct = 0;
    phase_cap = '{7'd127, 7'd3, 7'd0, 7'd1, 7'd64, 7'd64, 7'd100, 7'd2, 7'd64};
    phase_enq = '{85, 40, 50, 55, 60, 15, 65, 45, 55};
    phase_len = '{180, 150, 80, 120, 250, 200, 280, 200, 415};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty dequeue, extremes, ties at the middle and at the head
    send_request(CMD_DEQ, '0, '0);
    send_request(CMD_ENQ, 32'h8000_0000, 16'h5555);
    send_request(CMD_ENQ, 32'h0000_0000, 16'h0000);
    send_request(CMD_ENQ, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(CMD_ENQ, 32'h8000_0000, 16'hAAAA);
    send_request(CMD_ENQ, 32'h0000_0000, 16'h0001);
    repeat (6) send_request(CMD_DEQ, 32'hFFFF_FFFF, 16'hFFFF);

    // Capacity of one: second enqueue refused
    write_capacity(7'd1);
    send_request(CMD_ENQ, 32'd5, 16'd1);
    send_request(CMD_ENQ, 32'd3, 16'd2);
    send_request(CMD_DEQ, '0, '0);
    send_request(CMD_DEQ, '0, '0);

    // Capacity zero refuses every enqueue
    write_capacity(7'd0);
    send_request(CMD_ENQ, 32'd9, 16'd9);
    send_request(CMD_DEQ, '0, '0);

    // Capacity lowered under occupancy: nothing dropped, dequeues go on
    write_capacity(7'd64);
    send_request(CMD_ENQ, 32'd30, 16'h0030);
    send_request(CMD_ENQ, 32'd10, 16'h0010);
    send_request(CMD_ENQ, 32'd20, 16'h0020);
    write_capacity(7'd2);
    send_request(CMD_ENQ, 32'd1, 16'h0001);
    repeat (3) send_request(CMD_DEQ, '0, '0);

    // Random phases; occupancy carries over between them
    for (p = 0; p < PHASES; p++) begin
      write_capacity(phase_cap[p]);
      if (p == PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       gap_pct = 0;
          1:       gap_pct = 5;
          2:       gap_pct = 20;
          default: gap_pct = 45;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 3;
          default: stall_pct = 10;
        endcase
      end
      for (n = 0; n < phase_len[p]; n++) begin
        if (p != PHASES - 1 && $urandom_range(0, 149) == 0) drain_results();
        if ($urandom_range(1, 100) <= phase_enq[p])
          send_request(CMD_ENQ, pick_key(), TAG_BITS'($urandom));
        else
          send_request(CMD_DEQ, KEY_BITS'($urandom), TAG_BITS'($urandom));
      end
    end

    in_chan.valid <= 1'b0;
    do @(negedge clk); while (owed_count != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/smpq_pkg.sv
hdl/smpq_in_if.sv
hdl/smpq_out_if.sv
hdl/smpq_ram.sv
hdl/smpq_ctrl.sv
hdl/smpq_dp.sv
hdl/sorted_min_priority_queue_core.sv
tb/smpq_order_checker.sv
tb/tb.sv
